/* src/assert_macros.svh */
// Assertion macros shared by the request line parser modules.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define HRLP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define HRLP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* src/hrlp_pkg.sv */
// Shared constants, types and character helpers of the request line parser.
// No dependencies; used by every module of the block.
package hrlp_pkg;

	localparam int METHOD_LIMIT = 8;
	localparam int PATH_BUFFER  = 1024;
	localparam int INDEX_LEN    = 10;

	localparam int READ_LIMIT = METHOD_LIMIT + PATH_BUFFER + INDEX_LEN + 10;
	localparam int LOC_MAX    = PATH_BUFFER - INDEX_LEN - 1;
	localparam int CNT_W      = $clog2(READ_LIMIT + 1);
	localparam int IDX_W      = $clog2(INDEX_LEN + 1);

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_QMARK = 8'h3f;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_MISSING   = 3'd1;
	localparam logic [2:0] ST_BAD_METH  = 3'd2;
	localparam logic [2:0] ST_ESC_ROOT  = 3'd3;
	localparam logic [2:0] ST_TOO_LONG  = 3'd4;

	localparam logic [1:0] DD_NONE  = 2'd0;
	localparam logic [1:0] DD_SLASH = 2'd1;
	localparam logic [1:0] DD_DOT   = 2'd2;

	localparam logic [1:0] ESC_IDLE  = 2'd0;
	localparam logic [1:0] ESC_FIRST = 2'd1;
	localparam logic [1:0] ESC_SECND = 2'd2;
	localparam logic [1:0] ESC_BAD   = 2'd3;

	localparam logic [1:0] ALIVE_GET  = 2'b01;
	localparam logic [1:0] ALIVE_HEAD = 2'b10;
	localparam logic [1:0] ALIVE_BOTH = 2'b11;

	typedef enum logic [5:0] {
		PH_SKIP0  = 6'b000001,
		PH_METHOD = 6'b000010,
		PH_SKIP1  = 6'b000100,
		PH_LOC    = 6'b001000,
		PH_DONE   = 6'b010000,
		PH_STOP   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// One front-end request: optional path byte, optional index append,
	// optional final status, emitted by the back end in that order.
	typedef struct packed {
		logic       byte_v;
		logic [7:0] byte_val;
		logic       index_v;
		logic       status_v;
		logic [2:0] status;
	} cmd_t;

	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.val = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			h.val = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			h.val = 4'(b - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic logic [7:0] get_char(input logic [1:0] i);
		logic [7:0] c;
		case (i)
			2'd0: c = 8'h47;
			2'd1: c = 8'h45;
			2'd2: c = 8'h54;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] head_char(input logic [1:0] i);
		logic [7:0] c;
		case (i)
			2'd0: c = 8'h48;
			2'd1: c = 8'h45;
			2'd2: c = 8'h41;
			default: c = 8'h44;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] index_char(input logic [IDX_W-1:0] i);
		logic [7:0] c;
		case (i)
			IDX_W'(0): c = 8'h69;
			IDX_W'(1): c = 8'h6e;
			IDX_W'(2): c = 8'h64;
			IDX_W'(3): c = 8'h65;
			IDX_W'(4): c = 8'h78;
			IDX_W'(5): c = 8'h2e;
			IDX_W'(6): c = 8'h68;
			IDX_W'(7): c = 8'h74;
			IDX_W'(8): c = 8'h6d;
			IDX_W'(9): c = 8'h6c;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

/* src/hrlp_front.sv */
// Front end: takes one request byte per cycle while the queue is not full, runs the request
// line parser and issues at most one request per byte into the command queue. Uses hrlp_pkg.
`include "assert_macros.svh"

module hrlp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             full,
	input  logic [7:0]       req_byte,
	input  logic             end_of_data,
	output logic             cmd_push,
	output hrlp_pkg::cmd_t   cmd
);

	hrlp_pkg::phase_t            phase_q, ph_n;
	logic [2:0]                  mp_q, mp_n;
	logic [1:0]                  alive_q, al_n;
	logic [hrlp_pkg::CNT_W-1:0]  tl_q, tl_n;
	logic [hrlp_pkg::CNT_W-1:0]  bs_q, bs_n;
	logic [1:0]                  dd_q, dd_n;
	logic                        ree_q, ree_n;
	logic                        iq_q, iq_n;
	logic [1:0]                  esc_q, esc_n;
	logic [7:0]                  hex_q, hex_n;
	logic [7:0]                  lpb_q, lpb_n;
	logic                        pn_q, pn_n;
	logic [2:0]                  err_q, err_n;

	logic                        take;
	logic                        ws, stop, meth_step, loc_step, fin, dec_v, meth_ok;
	logic [7:0]                  dec_val, hex_t2;
	logic [1:0]                  alive_new;
	hrlp_pkg::hex_t              hx;

	assign take = push && !full;

	always_comb begin
		ph_n  = phase_q;
		mp_n  = mp_q;
		al_n  = alive_q;
		tl_n  = tl_q;
		bs_n  = bs_q;
		dd_n  = dd_q;
		ree_n = ree_q;
		iq_n  = iq_q;
		esc_n = esc_q;
		hex_n = hex_q;
		lpb_n = lpb_q;
		pn_n  = pn_q;
		err_n = err_q;
		meth_step = 1'b0;
		loc_step  = 1'b0;
		fin       = 1'b0;
		dec_v     = 1'b0;
		dec_val   = req_byte;
		alive_new = 2'b00;
		hex_t2    = hex_q;
		ws   = (req_byte == hrlp_pkg::CH_SPACE) ||
		       (req_byte >= hrlp_pkg::CH_TAB && req_byte <= hrlp_pkg::CH_CR);
		stop = (bs_q >= hrlp_pkg::CNT_W'(hrlp_pkg::READ_LIMIT)) ||
		       (req_byte == hrlp_pkg::CH_NUL);
		hx   = hrlp_pkg::hex_decode(req_byte);
		meth_ok = (alive_q[0] && mp_q == 3'd3) || (alive_q[1] && mp_q == 3'd4);

		unique case (phase_q)
			hrlp_pkg::PH_SKIP0: begin
				if (stop) begin
					ph_n = hrlp_pkg::PH_STOP;
				end else begin
					bs_n = bs_q + 1'b1;
					if (!ws) begin
						ph_n = hrlp_pkg::PH_METHOD;
						meth_step = 1'b1;
					end
				end
			end
			hrlp_pkg::PH_METHOD: begin
				if (stop) begin
					ph_n = hrlp_pkg::PH_STOP;
				end else begin
					bs_n = bs_q + 1'b1;
					if (ws) begin
						if (tl_q > hrlp_pkg::CNT_W'(hrlp_pkg::METHOD_LIMIT - 1)) begin
							if (err_q == hrlp_pkg::ST_OK) err_n = hrlp_pkg::ST_TOO_LONG;
						end else if (!meth_ok) begin
							if (err_q == hrlp_pkg::ST_OK) err_n = hrlp_pkg::ST_BAD_METH;
						end
						ph_n = hrlp_pkg::PH_SKIP1;
						tl_n = '0;
					end else begin
						meth_step = 1'b1;
					end
				end
			end
			hrlp_pkg::PH_SKIP1: begin
				if (stop) begin
					ph_n = hrlp_pkg::PH_STOP;
				end else begin
					bs_n = bs_q + 1'b1;
					if (!ws) begin
						ph_n = hrlp_pkg::PH_LOC;
						loc_step = 1'b1;
					end
				end
			end
			hrlp_pkg::PH_LOC: begin
				if (stop) begin
					fin  = 1'b1;
					ph_n = hrlp_pkg::PH_DONE;
				end else begin
					bs_n = bs_q + 1'b1;
					if (ws) begin
						fin  = 1'b1;
						ph_n = hrlp_pkg::PH_DONE;
					end else begin
						loc_step = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		if (meth_step) begin
			if (tl_q != '1) tl_n = tl_q + 1'b1;
			if (alive_q[0] && mp_q < 3'd3 && req_byte == hrlp_pkg::get_char(mp_q[1:0]))
				alive_new = alive_new | hrlp_pkg::ALIVE_GET;
			if (alive_q[1] && mp_q < 3'd4 && req_byte == hrlp_pkg::head_char(mp_q[1:0]))
				alive_new = alive_new | hrlp_pkg::ALIVE_HEAD;
			al_n = alive_new;
			if (mp_q != 3'd7) mp_n = mp_q + 1'b1;
		end

		if (loc_step) begin
			if (tl_q >= hrlp_pkg::CNT_W'(hrlp_pkg::LOC_MAX)) begin
				if (err_q == hrlp_pkg::ST_OK) err_n = hrlp_pkg::ST_TOO_LONG;
				ph_n = hrlp_pkg::PH_DONE;
			end else begin
				tl_n = tl_q + 1'b1;
				if (req_byte == hrlp_pkg::CH_SLASH) begin
					dd_n = hrlp_pkg::DD_SLASH;
				end else if (req_byte == hrlp_pkg::CH_DOT && dd_q == hrlp_pkg::DD_SLASH) begin
					dd_n = hrlp_pkg::DD_DOT;
				end else if (req_byte == hrlp_pkg::CH_DOT && dd_q == hrlp_pkg::DD_DOT) begin
					ree_n = 1'b1;
					dd_n  = hrlp_pkg::DD_NONE;
				end else begin
					dd_n = hrlp_pkg::DD_NONE;
				end
				if (!iq_q) begin
					if (esc_q == hrlp_pkg::ESC_IDLE) begin
						if (req_byte == hrlp_pkg::CH_QMARK) begin
							iq_n = 1'b1;
						end else if (req_byte == hrlp_pkg::CH_PCT) begin
							esc_n = hrlp_pkg::ESC_FIRST;
							hex_n = 8'd0;
						end else begin
							dec_v   = 1'b1;
							dec_val = req_byte;
						end
					end else if (req_byte == hrlp_pkg::CH_QMARK) begin
						dec_v   = 1'b1;
						dec_val = hex_q;
						esc_n   = hrlp_pkg::ESC_IDLE;
						iq_n    = 1'b1;
					end else if (esc_q == hrlp_pkg::ESC_FIRST) begin
						if (hx.ok) begin
							hex_n = {4'd0, hx.val};
							esc_n = hrlp_pkg::ESC_SECND;
						end else begin
							esc_n = hrlp_pkg::ESC_BAD;
						end
					end else begin
						if (esc_q == hrlp_pkg::ESC_SECND && hx.ok) hex_t2 = {hex_q[3:0], hx.val};
						hex_n   = hex_t2;
						dec_v   = 1'b1;
						dec_val = hex_t2;
						esc_n   = hrlp_pkg::ESC_IDLE;
					end
				end
			end
		end

		if (end_of_data) begin
			if (ph_n == hrlp_pkg::PH_LOC) begin
				fin  = 1'b1;
				ph_n = hrlp_pkg::PH_DONE;
			end else if (ph_n == hrlp_pkg::PH_SKIP0 || ph_n == hrlp_pkg::PH_METHOD ||
			             ph_n == hrlp_pkg::PH_SKIP1) begin
				ph_n = hrlp_pkg::PH_STOP;
			end
		end

		// pending escape is flushed when the token ends
		if (fin && !iq_n && esc_n != hrlp_pkg::ESC_IDLE) begin
			dec_v   = 1'b1;
			dec_val = hex_n;
			esc_n   = hrlp_pkg::ESC_IDLE;
		end

		cmd.byte_v   = 1'b0;
		cmd.byte_val = dec_val;
		if (dec_v) begin
			if (!pn_q) pn_n = 1'b1;
			else cmd.byte_v = (err_q == hrlp_pkg::ST_OK);
			lpb_n = dec_val;
		end

		cmd.index_v  = fin && err_n == hrlp_pkg::ST_OK && pn_n && lpb_n == hrlp_pkg::CH_SLASH;
		cmd.status_v = end_of_data;
		if (ph_n != hrlp_pkg::PH_DONE) cmd.status = hrlp_pkg::ST_MISSING;
		else if (err_n != hrlp_pkg::ST_OK) cmd.status = err_n;
		else if (ree_n) cmd.status = hrlp_pkg::ST_ESC_ROOT;
		else cmd.status = hrlp_pkg::ST_OK;
	end

	assign cmd_push = take && (cmd.byte_v || cmd.index_v || cmd.status_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hrlp_pkg::PH_SKIP0;
			mp_q    <= 3'd0;
			alive_q <= hrlp_pkg::ALIVE_BOTH;
			tl_q    <= '0;
			bs_q    <= '0;
			dd_q    <= hrlp_pkg::DD_NONE;
			ree_q   <= 1'b0;
			iq_q    <= 1'b0;
			esc_q   <= hrlp_pkg::ESC_IDLE;
			hex_q   <= 8'd0;
			lpb_q   <= 8'd0;
			pn_q    <= 1'b0;
			err_q   <= hrlp_pkg::ST_OK;
		end else if (take) begin
			if (end_of_data) begin
				phase_q <= hrlp_pkg::PH_SKIP0;
				mp_q    <= 3'd0;
				alive_q <= hrlp_pkg::ALIVE_BOTH;
				tl_q    <= '0;
				bs_q    <= '0;
				dd_q    <= hrlp_pkg::DD_NONE;
				ree_q   <= 1'b0;
				iq_q    <= 1'b0;
				esc_q   <= hrlp_pkg::ESC_IDLE;
				hex_q   <= 8'd0;
				lpb_q   <= 8'd0;
				pn_q    <= 1'b0;
				err_q   <= hrlp_pkg::ST_OK;
			end else begin
				phase_q <= ph_n;
				mp_q    <= mp_n;
				alive_q <= al_n;
				tl_q    <= tl_n;
				bs_q    <= bs_n;
				dd_q    <= dd_n;
				ree_q   <= ree_n;
				iq_q    <= iq_n;
				esc_q   <= esc_n;
				hex_q   <= hex_n;
				lpb_q   <= lpb_n;
				pn_q    <= pn_n;
				err_q   <= err_n;
			end
		end
	end

	`HRLP_ASSERT(a_eod_restarts, take && end_of_data |=> phase_q == hrlp_pkg::PH_SKIP0 && !pn_q, "request end did not restart parser")
	`HRLP_NEVER(a_path_after_done, take && cmd.byte_v && phase_q != hrlp_pkg::PH_LOC, "path byte outside location token")

endmodule

/* src/hrlp_cmd_fifo.sv */
// Short request queue between parser front end and output back end.
// Register array with count; depth from hrlp_pkg.
`include "assert_macros.svh"

module hrlp_cmd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  hrlp_pkg::cmd_t   wr_data,
	input  logic             rd_en,
	output hrlp_pkg::cmd_t   rd_data,
	output logic             full,
	output logic             nonempty
);

	hrlp_pkg::cmd_t                 mem_q [hrlp_pkg::CMDQ_DEPTH];
	logic [hrlp_pkg::CMDQ_AW-1:0]   wp_q, rp_q;
	logic [hrlp_pkg::CMDQ_AW:0]     cnt_q;

	assign full     = (cnt_q == (hrlp_pkg::CMDQ_AW+1)'(hrlp_pkg::CMDQ_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (rd_en) rp_q <= rp_q + 1'b1;
			if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en) cnt_q <= cnt_q - 1'b1;
		end
	end

	`HRLP_NEVER(a_push_when_full, wr_en && full, "request queue overflow")
	`HRLP_NEVER(a_pop_when_empty, rd_en && !nonempty, "request queue underflow")

endmodule

/* src/hrlp_back.sv */
// Back end: expands queued requests into result items (path byte, index
// name bytes, status) and holds them in the output register. Uses hrlp_pkg.
`include "assert_macros.svh"

module hrlp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  hrlp_pkg::cmd_t   cmd,
	output logic             cmd_pop,
	output logic             empty,
	input  logic             pop,
	output logic             out_kind,
	output logic [7:0]       out_byte,
	output logic [2:0]       status_code,
	output logic             run_last
);

	logic                        out_v_q;
	logic                        kind_q, last_q;
	logic [7:0]                  byte_q;
	logic [2:0]                  st_q;
	logic                        byte_done_q;
	logic [hrlp_pkg::IDX_W-1:0]  idx_q;

	logic                        load, cmd_end;
	logic                        n_kind, n_last;
	logic [7:0]                  n_byte;
	logic [2:0]                  n_st;
	logic                        sel_byte, sel_idx;

	assign load = cmd_valid && (!out_v_q || pop);

	always_comb begin
		sel_byte = cmd.byte_v && !byte_done_q;
		sel_idx  = !sel_byte && cmd.index_v && idx_q < hrlp_pkg::IDX_W'(hrlp_pkg::INDEX_LEN);
		n_kind   = 1'b0;
		n_last   = 1'b0;
		n_st     = hrlp_pkg::ST_OK;
		n_byte   = 8'd0;
		cmd_end  = 1'b0;
		if (sel_byte) begin
			n_byte  = cmd.byte_val;
			cmd_end = !cmd.index_v && !cmd.status_v;
		end else if (sel_idx) begin
			n_byte  = hrlp_pkg::index_char(idx_q);
			cmd_end = (idx_q == hrlp_pkg::IDX_W'(hrlp_pkg::INDEX_LEN - 1)) && !cmd.status_v;
		end else begin
			n_kind  = 1'b1;
			n_last  = 1'b1;
			n_st    = cmd.status;
			cmd_end = 1'b1;
		end
	end

	assign cmd_pop = load && cmd_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q     <= 1'b0;
			byte_done_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
			if (load) begin
				if (cmd_end) begin
					byte_done_q <= 1'b0;
					idx_q       <= '0;
				end else if (sel_byte) begin
					byte_done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= n_kind;
			last_q <= n_last;
			byte_q <= n_byte;
			st_q   <= n_st;
		end
	end

	assign empty       = !out_v_q;
	assign out_kind    = kind_q;
	assign out_byte    = byte_q;
	assign status_code = st_q;
	assign run_last    = last_q;

	`HRLP_NEVER(a_idx_range, idx_q > hrlp_pkg::IDX_W'(hrlp_pkg::INDEX_LEN), "index append overrun")
	`HRLP_ASSERT(a_progress_clears, cmd_pop |=> idx_q == '0 && !byte_done_q, "stale expansion progress")

endmodule

/* src/http_request_line_parser.sv */
// HTTP request line parser with percent decoding: top level.
// Path: each result is registered in the request queue and then in the output register.
// Throughput: one request byte per cycle while full is low; a byte that ends the path with '/'
// expands to up to 12 results at one per cycle while they are popped, buffered by a 4-entry queue.
// Reset: arst_n clears parser state, queue and output register at once.
// Depends on hrlp_pkg, hrlp_front, hrlp_cmd_fifo and hrlp_back.
module http_request_line_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  req_byte,
	input  logic        end_of_data,
	output logic        empty,
	input  logic        pop,
	output logic        out_kind,
	output logic [7:0]  out_byte,
	output logic [2:0]  status_code,
	output logic        run_last
);

	hrlp_pkg::cmd_t  fr_cmd, q_cmd;
	logic            fr_push, q_pop, q_nonempty;

	hrlp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_byte    (req_byte),
		.end_of_data (end_of_data),
		.cmd_push    (fr_push),
		.cmd         (fr_cmd)
	);

	hrlp_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fr_push),
		.wr_data  (fr_cmd),
		.rd_en    (q_pop),
		.rd_data  (q_cmd),
		.full     (full),
		.nonempty (q_nonempty)
	);

	hrlp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (q_nonempty),
		.cmd         (q_cmd),
		.cmd_pop     (q_pop),
		.empty       (empty),
		.pop         (pop),
		.out_kind    (out_kind),
		.out_byte    (out_byte),
		.status_code (status_code),
		.run_last    (run_last)
	);

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for http_request_line_parser: drives requests byte by byte,
// predicts the decoded location bytes, index name bytes and status items, and checks each result popped.
// Depends on hrlp_pkg and the http_request_line_parser RTL.
module tb_top;

	typedef struct {
		logic       kind;
		logic [7:0] data;
		logic [2:0] code;
		logic       last;
	} line_item_t;

	localparam int WATCHDOG_LIMIT = 5000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] req_byte = 8'h00;
	logic       end_of_data = 1'b0;
	logic       pop = 1'b0;
	logic       full, empty, out_kind, run_last;
	logic [7:0] out_byte;
	logic [2:0] status_code;

	line_item_t parsed_q[$];
	int err_cnt = 0;
	int items_sent = 0;
	int hold_len = 0;
	bit idle_en = 1'b1;

	// predicted parser state
	hrlp_pkg::phase_t ph;
	int         meth_pos, tok_len, text_cnt;
	logic [1:0] meth_alive, dd_state, esc_state;
	logic [7:0] hex_acc, last_path;
	logic       root_esc, in_q, path_started;
	logic [2:0] err_code;

	string w_get = "GET";
	string w_head = "HEAD";
	string w_index = "index.html";
	string hex_digits = "0123456789abcdefABCDEF";
	string near_miss [7] = '{"GE", "GETT", "HEA", "HEADS", "get", "POST", "HGET"};

	http_request_line_parser u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_byte(req_byte),
		.end_of_data(end_of_data),
		.empty(empty),
		.pop(pop),
		.out_kind(out_kind),
		.out_byte(out_byte),
		.status_code(status_code),
		.run_last(run_last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_parser();
		ph = hrlp_pkg::PH_SKIP0;
		meth_pos = 0;
		meth_alive = hrlp_pkg::ALIVE_BOTH;
		tok_len = 0;
		text_cnt = 0;
		dd_state = hrlp_pkg::DD_NONE;
		root_esc = 1'b0;
		in_q = 1'b0;
		esc_state = hrlp_pkg::ESC_IDLE;
		hex_acc = 8'h00;
		last_path = 8'h00;
		path_started = 1'b0;
		err_code = hrlp_pkg::ST_OK;
	endfunction

	function automatic void emit(logic kind, logic [7:0] data, logic [2:0] code, logic last);
		line_item_t it;
		it.kind = kind;
		it.data = data;
		it.code = code;
		it.last = last;
		parsed_q.push_back(it);
	endfunction

	function automatic void record_err(logic [2:0] code);
		if (err_code == hrlp_pkg::ST_OK) begin
			err_code = code;
		end
	endfunction

	function automatic int hex_val(logic [7:0] b);
		if (b >= "0" && b <= "9") begin
			return int'(b) - int'("0");
		end
		if (b >= "a" && b <= "f") begin
			return int'(b) - int'("a") + 10;
		end
		if (b >= "A" && b <= "F") begin
			return int'(b) - int'("A") + 10;
		end
		return -1;
	endfunction

	function automatic logic is_ws(logic [7:0] b);
		return b == hrlp_pkg::CH_SPACE || (b >= hrlp_pkg::CH_TAB && b <= hrlp_pkg::CH_CR);
	endfunction

	// first decoded byte only marks the path as started
	function automatic void path_byte(logic [7:0] b);
		if (!path_started) begin
			path_started = 1'b1;
		end else if (err_code == hrlp_pkg::ST_OK) begin
			emit(1'b0, b, hrlp_pkg::ST_OK, 1'b0);
		end
		last_path = b;
	endfunction

	function automatic void meth_byte(logic [7:0] b);
		logic [1:0] alive;
		alive = 2'b00;
		if (tok_len < 2047) begin
			tok_len++;
		end
		if ((meth_alive & hrlp_pkg::ALIVE_GET) != 0 && meth_pos < 3 && b == w_get[meth_pos]) begin
			alive |= hrlp_pkg::ALIVE_GET;
		end
		if ((meth_alive & hrlp_pkg::ALIVE_HEAD) != 0 && meth_pos < 4 &&
		    b == w_head[meth_pos]) begin
			alive |= hrlp_pkg::ALIVE_HEAD;
		end
		meth_alive = alive;
		if (meth_pos < 7) begin
			meth_pos++;
		end
	endfunction

	function automatic void meth_end();
		logic ok;
		ok = ((meth_alive & hrlp_pkg::ALIVE_GET) != 0 && meth_pos == 3) ||
			((meth_alive & hrlp_pkg::ALIVE_HEAD) != 0 && meth_pos == 4);
		if (tok_len > hrlp_pkg::METHOD_LIMIT - 1) begin
			record_err(hrlp_pkg::ST_TOO_LONG);
		end else if (!ok) begin
			record_err(hrlp_pkg::ST_BAD_METH);
		end
	endfunction

	function automatic void loc_byte(logic [7:0] b);
		int d;
		if (tok_len >= hrlp_pkg::LOC_MAX) begin
			record_err(hrlp_pkg::ST_TOO_LONG);
			ph = hrlp_pkg::PH_DONE;
			return;
		end
		tok_len++;
		if (b == hrlp_pkg::CH_SLASH) begin
			dd_state = hrlp_pkg::DD_SLASH;
		end else if (b == hrlp_pkg::CH_DOT && dd_state == hrlp_pkg::DD_SLASH) begin
			dd_state = hrlp_pkg::DD_DOT;
		end else if (b == hrlp_pkg::CH_DOT && dd_state == hrlp_pkg::DD_DOT) begin
			root_esc = 1'b1;
			dd_state = hrlp_pkg::DD_NONE;
		end else begin
			dd_state = hrlp_pkg::DD_NONE;
		end
		if (in_q) begin
			return;
		end
		if (esc_state == hrlp_pkg::ESC_IDLE) begin
			if (b == hrlp_pkg::CH_QMARK) begin
				in_q = 1'b1;
			end else if (b == hrlp_pkg::CH_PCT) begin
				esc_state = hrlp_pkg::ESC_FIRST;
				hex_acc = 8'h00;
			end else begin
				path_byte(b);
			end
			return;
		end
		if (b == hrlp_pkg::CH_QMARK) begin
			path_byte(hex_acc);
			esc_state = hrlp_pkg::ESC_IDLE;
			in_q = 1'b1;
			return;
		end
		d = hex_val(b);
		if (esc_state == hrlp_pkg::ESC_FIRST) begin
			if (d >= 0) begin
				hex_acc = 8'(d);
				esc_state = hrlp_pkg::ESC_SECND;
			end else begin
				esc_state = hrlp_pkg::ESC_BAD;
			end
		end else begin
			if (esc_state == hrlp_pkg::ESC_SECND && d >= 0) begin
				hex_acc = {hex_acc[3:0], 4'(d)};
			end
			path_byte(hex_acc);
			esc_state = hrlp_pkg::ESC_IDLE;
		end
	endfunction

	function automatic void loc_end();
		if (!in_q && esc_state != hrlp_pkg::ESC_IDLE) begin
			path_byte(hex_acc);
			esc_state = hrlp_pkg::ESC_IDLE;
		end
		if (err_code == hrlp_pkg::ST_OK && path_started && last_path == hrlp_pkg::CH_SLASH) begin
			for (int i = 0; i < hrlp_pkg::INDEX_LEN; i++) begin
				emit(1'b0, w_index[i], hrlp_pkg::ST_OK, 1'b0);
			end
		end
	endfunction

	function automatic void stop_text();
		if (ph == hrlp_pkg::PH_LOC) begin
			loc_end();
			ph = hrlp_pkg::PH_DONE;
		end else if (ph == hrlp_pkg::PH_SKIP0 || ph == hrlp_pkg::PH_METHOD ||
		             ph == hrlp_pkg::PH_SKIP1) begin
			ph = hrlp_pkg::PH_STOP;
		end
	endfunction

	function automatic void take_byte(logic [7:0] b);
		case (ph)
			hrlp_pkg::PH_SKIP0: begin
				if (!is_ws(b)) begin
					ph = hrlp_pkg::PH_METHOD;
					meth_byte(b);
				end
			end
			hrlp_pkg::PH_METHOD: begin
				if (is_ws(b)) begin
					meth_end();
					ph = hrlp_pkg::PH_SKIP1;
					tok_len = 0;
				end else begin
					meth_byte(b);
				end
			end
			hrlp_pkg::PH_SKIP1: begin
				if (!is_ws(b)) begin
					ph = hrlp_pkg::PH_LOC;
					loc_byte(b);
				end
			end
			hrlp_pkg::PH_LOC: begin
				if (is_ws(b)) begin
					loc_end();
					ph = hrlp_pkg::PH_DONE;
				end else begin
					loc_byte(b);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void parse_byte(logic [7:0] b, logic eod);
		logic [2:0] st;
		if (ph != hrlp_pkg::PH_DONE && ph != hrlp_pkg::PH_STOP) begin
			if (text_cnt >= hrlp_pkg::READ_LIMIT || b == hrlp_pkg::CH_NUL) begin
				stop_text();
			end else begin
				text_cnt++;
				take_byte(b);
			end
		end
		if (eod) begin
			stop_text();
			if (ph != hrlp_pkg::PH_DONE) begin
				st = hrlp_pkg::ST_MISSING;
			end else if (err_code != hrlp_pkg::ST_OK) begin
				st = err_code;
			end else if (root_esc) begin
				st = hrlp_pkg::ST_ESC_ROOT;
			end else begin
				st = hrlp_pkg::ST_OK;
			end
			emit(1'b1, 8'h00, st, 1'b1);
			clear_parser();
		end
	endfunction

	function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_cnt++;
		end
	endfunction

	function automatic void check_result();
		line_item_t w;
		if (parsed_q.size() == 0) begin
			$error("unexpected result: kind %0d byte %0h status %0d last %0d",
				out_kind, out_byte, status_code, run_last);
			err_cnt++;
			return;
		end
		w = parsed_q.pop_front();
		cmp_field("out_kind", 8'(w.kind), 8'(out_kind));
		cmp_field("out_byte", w.data, out_byte);
		cmp_field("status_code", 8'(w.code), 8'(status_code));
		cmp_field("run_last", 8'(w.last), 8'(run_last));
	endfunction

	// called at a rising edge; returns at the edge where the request is taken
	task automatic send_req(input logic [7:0] b, input logic eod);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		push <= 1'b1;
		req_byte <= b;
		end_of_data <= eod;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
		parse_byte(b, eod);
	endtask

	task automatic send_line(ref logic [7:0] q[$]);
		foreach (q[i]) begin
			send_req(q[i], i == q.size() - 1);
		end
	endtask

	function automatic void add_str(ref logic [7:0] q[$], input string s);
		for (int i = 0; i < s.len(); i++) begin
			q.push_back(s[i]);
		end
	endfunction

	function automatic logic [7:0] ws_char();
		int k;
		k = $urandom_range(8, 13);
		return (k == 8) ? hrlp_pkg::CH_SPACE : 8'(k);
	endfunction

	function automatic logic [7:0] hex_char();
		return hex_digits[$urandom_range(0, 21)];
	endfunction

	function automatic logic [7:0] print_char();
		return 8'($urandom_range(8'h21, 8'h7e));
	endfunction

	function automatic void add_piece(ref logic [7:0] q[$]);
		case ($urandom_range(0, 12))
			0, 1, 2: q.push_back(8'($urandom_range(8'h61, 8'h7a)));
			3: q.push_back(hrlp_pkg::CH_SLASH);
			4: add_str(q, "/..");
			5: begin
				q.push_back(hrlp_pkg::CH_PCT);
				q.push_back(hex_char());
				q.push_back(hex_char());
			end
			6: begin
				q.push_back(hrlp_pkg::CH_PCT);
				q.push_back(hex_char());
				q.push_back(print_char());
			end
			7: begin
				q.push_back(hrlp_pkg::CH_PCT);
				q.push_back(print_char());
				q.push_back(print_char());
			end
			8: q.push_back(hrlp_pkg::CH_QMARK);
			9: q.push_back(8'($urandom_range(8'h80, 8'hff)));
			10: q.push_back(hrlp_pkg::CH_PCT);
			11: q.push_back(hrlp_pkg::CH_DOT);
			default: q.push_back($urandom_range(0, 3) == 0 ? hrlp_pkg::CH_NUL : print_char());
		endcase
	endfunction

	task automatic send_str(input string s);
		logic [7:0] q[$];
		add_str(q, s);
		send_line(q);
	endtask

	task automatic test_status_codes();
		send_str("GET /");
		send_str("PUT /a");
		send_str("HEAD /..");
		send_str("GET");
		send_req(8'hff, 1'b1);
	endtask

	task automatic test_escapes();
		logic [7:0] q[$];
		send_str("GET /%00%4g%?");
		send_str("GET /a%2");
		add_str(q, "GET /b");
		q.push_back(hrlp_pkg::CH_NUL);
		q.push_back("c");
		send_line(q);
	endtask

	task automatic test_method_length();
		send_str("GETHEAD /a");
		send_str("GETHEADGT /a");
	endtask

	task automatic test_backpressure();
		logic [7:0] q[$];
		hold_len = 300;
		add_str(q, "GET /");
		repeat (40) q.push_back(8'($urandom_range(8'h61, 8'h7a)));
		q.push_back(hrlp_pkg::CH_SLASH);
		send_line(q);
	endtask

	task automatic rand_request();
		logic [7:0] q[$];
		int k;
		int cut;
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 2)) q.push_back(ws_char());
			k = $urandom_range(0, 9);
			if (k < 4) begin
				add_str(q, "GET");
			end else if (k < 7) begin
				add_str(q, "HEAD");
			end else if (k < 9) begin
				add_str(q, near_miss[$urandom_range(0, 6)]);
			end else begin
				repeat ($urandom_range(1, 10)) q.push_back(8'($urandom_range(8'h41, 8'h5a)));
			end
			repeat ($urandom_range(1, 2)) q.push_back(ws_char());
			if ($urandom_range(0, 9) != 0) begin
				q.push_back(hrlp_pkg::CH_SLASH);
			end
			repeat ($urandom_range(0, 8)) add_piece(q);
			if ($urandom_range(0, 1) == 1) begin
				add_str(q, " H\r\n");
			end
			// truncated request
			if ($urandom_range(0, 9) == 0) begin
				cut = $urandom_range(1, q.size());
				while (q.size() > cut) void'(q.pop_back());
			end
		end
		send_line(q);
	endtask

	task automatic test_random(input int n_items);
		int start;
		start = items_sent;
		while (items_sent - start < n_items) begin
			idle_en = ($urandom_range(0, 3) != 0);
			rand_request();
		end
	endtask

	task automatic test_steady(input int n_items);
		int start;
		start = items_sent;
		idle_en = 1'b0;
		while (items_sent - start < n_items) begin
			rand_request();
		end
	endtask

	initial begin : result_side
		int stall;
		int hold;
		stall = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				check_result();
			end
			if (hold_len != 0) begin
				hold = hold_len;
				hold_len = 0;
			end
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 8);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("http_request_line_parser verification failed");
		$finish;
	end

	initial begin
		clear_parser();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_status_codes();
		test_escapes();
		test_method_length();
		test_backpressure();
		test_random(110);
		test_steady(30);
		push <= 1'b0;
		while (parsed_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (err_cnt == 0 && parsed_q.size() == 0) begin
			$display("http_request_line_parser verification clean");
		end else begin
			$display("http_request_line_parser verification failed");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/hrlp_pkg.sv
src/hrlp_front.sv
src/hrlp_cmd_fifo.sv
src/hrlp_back.sv
src/http_request_line_parser.sv
verif/tb_top.sv
